>>> design/peano_curve_segment_generator_macros.svh
// Assertion macros shared by the segment generator RTL.
// Simulation builds expand them into concurrent assertions; synthesis builds drop them.
`ifndef PEANO_CURVE_SEGMENT_GENERATOR_MACROS_SVH
`define PEANO_CURVE_SEGMENT_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PCSG_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define PCSG_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PCSG_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PCSG_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> design/pcsg_pkg.sv
// Types, constants and helper functions for the Peano curve segment generator.
// No dependencies; used by peano_curve_segment_generator.
package pcsg_pkg;

    // sizing
    localparam int MAX_DEPTH  = 6;
    localparam int COORD_BITS = 11;
    localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);

    // fixed field widths
    localparam int FIELD_W = 11;
    localparam int CHAN_W  = 8;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [FIELD_W-1:0]    t_field;
    typedef logic [DEPTH_W-1:0]    t_depth;
    typedef logic [3:0]            t_digit;
    typedef logic [5:0]            t_head;
    typedef logic [MAX_DEPTH-1:0][3:0] t_digits;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_CURVE_DEPTH = 2'd0,
        REG_STEP_LENGTH = 2'd1,
        REG_START_X     = 2'd2,
        REG_START_Y     = 2'd3
    } t_reg_idx;

    // heading count runs modulo 36
    localparam t_head  HEAD_MOD   = 6'd36;
    localparam t_head  HEAD_LAST  = 6'd35;
    localparam t_head  HEAD_START = 6'd28;
    localparam t_digit DIGIT_LAST = 4'd8;
    localparam t_digit TURN_A     = 4'd2;
    localparam t_digit TURN_B     = 4'd5;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // step the heading count one up or down with wrap
    function automatic t_head head_turn(t_head h, logic inc, logic dec);
        t_head r;
        r = h;
        if (inc) begin
            r = (h == HEAD_LAST) ? 6'd0 : h + 6'd1;
        end else if (dec) begin
            r = (h == 6'd0) ? HEAD_LAST : h - 6'd1;
        end
        return r;
    endfunction

    // heading count (below 36) modulo 9 by compare and subtract
    function automatic logic [3:0] mod9(t_head h);
        t_head r;
        if (h >= 6'd27) begin
            r = h - 6'd27;
        end else if (h >= 6'd18) begin
            r = h - 6'd18;
        end else if (h >= 6'd9) begin
            r = h - 6'd9;
        end else begin
            r = h;
        end
        return r[3:0];
    endfunction

    // nine-entry colour table
    function automatic t_rgb color_of(logic [3:0] idx);
        t_rgb c;
        case (idx)
            4'd0:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            4'd1:    c = '{red: 8'd85,  green: 8'd170, blue: 8'd0};
            4'd2:    c = '{red: 8'd170, green: 8'd85,  blue: 8'd0};
            4'd3:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            4'd4:    c = '{red: 8'd170, green: 8'd0,   blue: 8'd85};
            4'd5:    c = '{red: 8'd85,  green: 8'd0,   blue: 8'd170};
            4'd6:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            4'd7:    c = '{red: 8'd0,   green: 8'd85,  blue: 8'd170};
            4'd8:    c = '{red: 8'd0,   green: 8'd170, blue: 8'd85};
            default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
        endcase
        return c;
    endfunction

endpackage

>>> design/peano_curve_segment_generator.sv
// Peano curve segment generator: an accepted word reaches the output through the input
// register, then the result register; one word per cycle sustained while the output is not
// stalled, with the digit carry and heading update between the two registers.
// A word that yields no segment (curve finished or no digit left, no restart) is dropped.
// Synchronous active-low reset: depth 1, step 1, start 0,0, curve finished until restart.
// Depends on pcsg_pkg and peano_curve_segment_generator_macros.svh.
`include "peano_curve_segment_generator_macros.svh"

module peano_curve_segment_generator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [10:0]              i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_restart,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [10:0]              o_from_x,
    output logic [10:0]              o_from_y,
    output logic [10:0]              o_to_x,
    output logic [10:0]              o_to_y,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue,
    output logic                     o_last_segment
);

    localparam int MD = pcsg_pkg::MAX_DEPTH;

    // configuration registers
    logic [2:0]          r_curve_depth;
    logic [10:0]         r_step_length;
    logic [10:0]         r_start_x;
    logic [10:0]         r_start_y;

    // input register
    logic                r_in_valid;
    logic                r_in_restart;

    // curve state
    pcsg_pkg::t_digits   r_digits;
    pcsg_pkg::t_head     r_heading;
    pcsg_pkg::t_coord    r_pen_x;
    pcsg_pkg::t_coord    r_pen_y;
    logic                r_finished;

    // result register
    logic                r_out_valid;
    pcsg_pkg::t_field    r_from_x;
    pcsg_pkg::t_field    r_from_y;
    pcsg_pkg::t_field    r_to_x;
    pcsg_pkg::t_field    r_to_y;
    pcsg_pkg::t_rgb      r_rgb;
    logic                r_last;

    // next-state and datapath signals
    pcsg_pkg::t_depth    depth;
    pcsg_pkg::t_digits   eff_digits;
    pcsg_pkg::t_head     eff_heading;
    pcsg_pkg::t_coord    eff_pen_x;
    pcsg_pkg::t_coord    eff_pen_y;
    logic                eff_finished;
    logic [MD-1:0]       sel;
    logic                found;
    logic                parity;
    pcsg_pkg::t_digit    k;
    logic                turn_inc;
    logic                turn_dec;
    pcsg_pkg::t_head     dir;
    pcsg_pkg::t_coord    step;
    pcsg_pkg::t_digits   n_digits;
    pcsg_pkg::t_head     n_heading;
    pcsg_pkg::t_coord    n_pen_x;
    pcsg_pkg::t_coord    n_pen_y;
    logic                n_finished;
    logic                n_last;
    logic                emit;
    logic                adv;

    // clamp the depth into 1..MAX_DEPTH
    always_comb begin
        if (r_curve_depth == 3'd0) begin
            depth = pcsg_pkg::t_depth'(1);
        end else if (32'(r_curve_depth) > MD) begin
            depth = pcsg_pkg::t_depth'(MD);
        end else begin
            depth = pcsg_pkg::t_depth'(r_curve_depth);
        end
    end

    // state seen by this word: reloaded on restart
    always_comb begin
        if (r_in_restart) begin
            eff_digits   = '0;
            eff_heading  = pcsg_pkg::HEAD_START;
            eff_pen_x    = pcsg_pkg::t_coord'(r_start_x);
            eff_pen_y    = pcsg_pkg::t_coord'(r_start_y);
            eff_finished = 1'b0;
        end else begin
            eff_digits   = r_digits;
            eff_heading  = r_heading;
            eff_pen_x    = r_pen_x;
            eff_pen_y    = r_pen_y;
            eff_finished = r_finished;
        end
    end

    // pick the deepest active level whose digit is below 8
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = MD - 1; i >= 0; i--) begin
            sel[i] = !seen && (i < int'(depth)) && (eff_digits[i] != pcsg_pkg::DIGIT_LAST);
            seen   = seen | sel[i];
        end
        found = seen;
    end

    // digit of the chosen level and parity of the digits above it
    always_comb begin
        logic pa;
        pa     = 1'b0;
        parity = 1'b0;
        k      = '0;
        for (int i = 0; i < MD; i++) begin
            if (sel[i]) begin
                k      = eff_digits[i];
                parity = pa;
            end
            pa = pa ^ eff_digits[i][0];
        end
    end

    // turn before and after the stroke: odd parity turns up at stroke 2, down at stroke 5
    assign turn_inc = ((k == pcsg_pkg::TURN_A) && parity)
                   || ((k == pcsg_pkg::TURN_B) && !parity);
    assign turn_dec = ((k == pcsg_pkg::TURN_A) && !parity)
                   || ((k == pcsg_pkg::TURN_B) && parity);
    assign dir       = pcsg_pkg::head_turn(eff_heading, turn_inc, turn_dec);
    assign n_heading = pcsg_pkg::head_turn(dir, turn_inc, turn_dec);

    // move the pen one step along the heading
    assign step = pcsg_pkg::t_coord'(r_step_length);
    always_comb begin
        n_pen_x = eff_pen_x;
        n_pen_y = eff_pen_y;
        case (dir[1:0])
            2'd0:    n_pen_x = eff_pen_x + step;
            2'd1:    n_pen_y = eff_pen_y - step;
            2'd2:    n_pen_x = eff_pen_x - step;
            default: n_pen_y = eff_pen_y + step;
        endcase
    end

    // advance the chosen digit, clear the active digits below it
    always_comb begin
        logic passed;
        passed = 1'b0;
        for (int i = 0; i < MD; i++) begin
            if (sel[i]) begin
                n_digits[i] = eff_digits[i] + 4'd1;
            end else if (passed && (i < int'(depth))) begin
                n_digits[i] = '0;
            end else begin
                n_digits[i] = eff_digits[i];
            end
            passed = passed | sel[i];
        end
    end

    // final segment once every active digit reaches 8
    always_comb begin
        n_last = 1'b1;
        for (int i = 0; i < MD; i++) begin
            if ((i < int'(depth)) && (n_digits[i] != pcsg_pkg::DIGIT_LAST)) begin
                n_last = 1'b0;
            end
        end
    end

    assign emit       = !eff_finished && found;
    assign n_finished = emit ? n_last : 1'b1;

    // handshakes: the input register drains when the result register can take its segment or the word yields none
    assign adv         = r_in_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_depth <= 3'd1;
            r_step_length <= 11'd1;
            r_start_x     <= '0;
            r_start_y     <= '0;
        end else if (i_cfg_valid) begin
            unique case (pcsg_pkg::t_reg_idx'(i_cfg_index))
                pcsg_pkg::REG_CURVE_DEPTH: r_curve_depth <= i_cfg_data[2:0];
                pcsg_pkg::REG_STEP_LENGTH: r_step_length <= i_cfg_data;
                pcsg_pkg::REG_START_X:     r_start_x     <= i_cfg_data;
                pcsg_pkg::REG_START_Y:     r_start_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_restart <= i_restart;
        end
    end

    // curve state: advance when the held word leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits   <= '0;
            r_heading  <= pcsg_pkg::HEAD_START;
            r_pen_x    <= '0;
            r_pen_y    <= '0;
            r_finished <= 1'b1;
        end else if (adv) begin
            r_finished <= n_finished;
            if (emit) begin
                r_digits  <= n_digits;
                r_heading <= n_heading;
                r_pen_x   <= n_pen_x;
                r_pen_y   <= n_pen_y;
            end else begin
                r_digits  <= eff_digits;
                r_heading <= eff_heading;
                r_pen_x   <= eff_pen_x;
                r_pen_y   <= eff_pen_y;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && emit) begin
            r_from_x <= pcsg_pkg::t_field'(eff_pen_x);
            r_from_y <= pcsg_pkg::t_field'(eff_pen_y);
            r_to_x   <= pcsg_pkg::t_field'(n_pen_x);
            r_to_y   <= pcsg_pkg::t_field'(n_pen_y);
            r_rgb    <= pcsg_pkg::color_of(pcsg_pkg::mod9(dir));
            r_last   <= n_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_from_x       = r_from_x;
    assign o_from_y       = r_from_y;
    assign o_to_x         = r_to_x;
    assign o_to_y         = r_to_y;
    assign o_red          = r_rgb.red;
    assign o_green        = r_rgb.green;
    assign o_blue         = r_rgb.blue;
    assign o_last_segment = r_last;

    // a restarted curve never ends on its first segment
    `PCSG_ASSERT_NXT(a_restart_runs, i_clk, i_rst_n, adv && r_in_restart, !r_finished)
    // issuing the final segment leaves the curve finished
    `PCSG_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, adv && emit && n_last, r_finished)
    // a stalled result keeps a segment-producing word in the input register
    `PCSG_ASSERT_NXT(a_hold_word, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid)
    // the heading count stays below its modulus
    `PCSG_ASSERT_IMP(a_head_range, i_clk, i_rst_n, r_in_valid, r_heading < pcsg_pkg::HEAD_MOD)

endmodule

>>> test/tb_peano_curve_segment_generator.sv
// Self-checking testbench for peano_curve_segment_generator: directed and random words,
// register writes between phases, random stalls on both channels and a long output hold-off.
// Depends on pcsg_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb_peano_curve_segment_generator;

    localparam int HALF_NS      = 6;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PCT     = 24;
    localparam int SETTLE       = 4;
    localparam int TAIL         = 8;
    localparam int RANDOM_WORDS = 850;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 80;
    localparam int LIMIT_NS     = 400000 * 2 * HALF_NS;

    typedef enum logic {JOB_WORD, JOB_CFG} t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic               restart;
        pcsg_pkg::t_reg_idx idx;
        logic [10:0]        data;
    } t_job;

    typedef struct packed {
        pcsg_pkg::t_coord from_x;
        pcsg_pkg::t_coord from_y;
        pcsg_pkg::t_coord to_x;
        pcsg_pkg::t_coord to_y;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             last;
    } t_seg;

    // clock, reset and block inputs
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_valid = 1'b0;
    pcsg_pkg::t_reg_idx i_cfg_index = pcsg_pkg::REG_CURVE_DEPTH;
    logic [10:0]        i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic               i_restart   = 1'b0;
    logic               i_out_ready = 1'b0;

    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [10:0] o_from_x;
    logic [10:0] o_from_y;
    logic [10:0] o_to_x;
    logic [10:0] o_to_y;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_last_segment;

    // stimulus and expected segments
    t_job pending[$];
    t_seg segs_due[$];
    int   errors     = 0;
    int   words_sent = 0;
    int   segs_seen  = 0;
    int   since_word = SETTLE;
    int   hold_left  = 0;
    logic held       = 1'b0;

    // shadow registers and curve walker state
    pcsg_pkg::t_depth cfg_depth = 3'd1;
    pcsg_pkg::t_coord cfg_step  = 11'd1;
    pcsg_pkg::t_coord cfg_x     = '0;
    pcsg_pkg::t_coord cfg_y     = '0;
    pcsg_pkg::t_digit digit_of [pcsg_pkg::MAX_DEPTH];
    pcsg_pkg::t_head  heading    = pcsg_pkg::HEAD_START;
    pcsg_pkg::t_coord pen_x      = '0;
    pcsg_pkg::t_coord pen_y      = '0;
    logic             curve_done = 1'b1;

    // red, green, blue per heading count modulo 9
    logic [23:0] palette [0:8] = '{24'h00FF00, 24'h55AA00, 24'hAA5500, 24'hFF0000,
                                   24'hAA0055, 24'h5500AA, 24'h0000FF, 24'h0055AA,
                                   24'h00AA55};

    peano_curve_segment_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_from_x       (o_from_x),
        .o_from_y       (o_from_y),
        .o_to_x         (o_to_x),
        .o_to_y         (o_to_y),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_last_segment (o_last_segment)
    );

    always #HALF_NS i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < pcsg_pkg::MAX_DEPTH; i++) digit_of[i] = '0;
    end

    // step the heading count by -1, 0 or +1, modulo 36
    function automatic pcsg_pkg::t_head turn_head(input pcsg_pkg::t_head h, input int delta);
        int hv;
        hv = int'(h);
        hv = (hv + 36 + delta) % 36;
        return hv[5:0];
    endfunction

    // track a register write in the shadow copy
    function automatic void write_reg(input pcsg_pkg::t_reg_idx idx, input logic [10:0] data);
        case (idx)
            pcsg_pkg::REG_CURVE_DEPTH: cfg_depth = data[2:0];
            pcsg_pkg::REG_STEP_LENGTH: cfg_step  = data;
            pcsg_pkg::REG_START_X:     cfg_x     = data;
            default:                   cfg_y     = data;
        endcase
    endfunction

    // advance the curve by one accepted word, queue the segment it yields
    function automatic void walk_curve(input logic restart);
        int   eff;
        int   lvl;
        int   parity;
        int   turn;
        t_seg s;
        logic at_end;
        if (restart) begin
            for (int i = 0; i < pcsg_pkg::MAX_DEPTH; i++) digit_of[i] = '0;
            heading    = pcsg_pkg::HEAD_START;
            pen_x      = cfg_x;
            pen_y      = cfg_y;
            curve_done = 1'b0;
        end
        if (curve_done) return;
        eff = (cfg_depth == 0) ? 1 :
              (cfg_depth > pcsg_pkg::MAX_DEPTH) ? pcsg_pkg::MAX_DEPTH : int'(cfg_depth);
        // deepest level whose digit can still advance
        lvl = -1;
        for (int i = eff - 1; i >= 0 && lvl < 0; i--) begin
            if (digit_of[i] != pcsg_pkg::DIGIT_LAST) lvl = i;
        end
        if (lvl < 0) begin
            curve_done = 1'b1;
            return;
        end
        // sub-curve orientation follows the parity of the digits above
        parity = 0;
        for (int i = 0; i < lvl; i++) parity += int'(digit_of[i]);
        turn = parity[0] ? 1 : -1;
        if (digit_of[lvl] == pcsg_pkg::TURN_B) turn = -turn;
        else if (digit_of[lvl] != pcsg_pkg::TURN_A) turn = 0;
        heading  = turn_head(heading, turn);
        s.from_x = pen_x;
        s.from_y = pen_y;
        case (heading[1:0])
            2'd0:    pen_x = pen_x + cfg_step;
            2'd1:    pen_y = pen_y - cfg_step;
            2'd2:    pen_x = pen_x - cfg_step;
            default: pen_y = pen_y + cfg_step;
        endcase
        {s.red, s.green, s.blue} = palette[heading % 9];
        heading = turn_head(heading, turn);
        digit_of[lvl] = digit_of[lvl] + 4'd1;
        for (int i = lvl + 1; i < eff; i++) digit_of[i] = '0;
        at_end = 1'b1;
        for (int i = 0; i < eff; i++) begin
            if (digit_of[i] != pcsg_pkg::DIGIT_LAST) at_end = 1'b0;
        end
        curve_done = at_end;
        s.to_x = pen_x;
        s.to_y = pen_y;
        s.last = at_end;
        segs_due.push_back(s);
    endfunction

    task automatic check_field(input string name, input logic [10:0] want,
                               input logic [10:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic queue_word(input logic restart);
        pending.push_back('{kind: JOB_WORD, restart: restart,
                            idx: pcsg_pkg::REG_CURVE_DEPTH, data: 11'd0});
    endtask

    task automatic queue_cfg(input pcsg_pkg::t_reg_idx idx, input logic [10:0] data);
        pending.push_back('{kind: JOB_CFG, restart: 1'b0, idx: idx, data: data});
    endtask

    // depth write with random junk above the three depth bits
    function automatic logic [10:0] depth_data(input logic [2:0] d);
        logic [10:0] w;
        w      = 11'($urandom_range(0, 2047));
        w[2:0] = d;
        return w;
    endfunction

    function automatic logic [2:0] pick_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 3'd1;
        if (r < 82) return 3'd2;
        if (r < 88) return 3'd3;
        if (r < 92) return 3'd0;
        if (r < 96) return 3'd7;
        return 3'($urandom_range(4, 6));
    endfunction

    function automatic logic [10:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 11'd0;
        if (r < 20) return 11'd2047;
        if (r < 28) return 11'd1;
        return 11'($urandom_range(0, 2047));
    endfunction

    // driver: offer queued words and register writes, predict on acceptance
    always @(posedge i_clk) begin : feed
        logic in_v;
        logic cfg_v;
        in_v  = i_in_valid;
        cfg_v = i_cfg_valid;
        if (!i_rst_n) begin
            in_v  = 1'b0;
            cfg_v = 1'b0;
        end else begin
            // retire accepted words and writes
            if (i_in_valid && o_in_ready) begin
                walk_curve(i_restart);
                in_v       = 1'b0;
                since_word = 0;
                words_sent++;
            end else if (since_word < SETTLE) begin
                since_word++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_reg(i_cfg_index, i_cfg_data);
                cfg_v = 1'b0;
            end
            // offer the next job; writes only once the block has drained
            if (!in_v && !cfg_v && pending.size() != 0) begin
                if (pending[0].kind == JOB_WORD) begin
                    if ((words_sent >= 300 && words_sent < 420) ||
                        $urandom_range(0, 99) >= IDLE_PCT) begin
                        i_restart <= pending[0].restart;
                        in_v = 1'b1;
                        void'(pending.pop_front());
                    end
                end else if (segs_due.size() == 0 && since_word >= SETTLE) begin
                    i_cfg_index <= pending[0].idx;
                    i_cfg_data  <= pending[0].data;
                    cfg_v = 1'b1;
                    void'(pending.pop_front());
                end
            end
        end
        i_in_valid  <= in_v;
        i_cfg_valid <= cfg_v;
    end

    // monitor: compare each accepted segment, drive output stalls
    always @(posedge i_clk) begin : watch
        t_seg want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (segs_due.size() == 0) begin
                    $display("%0t: segment with none expected, from (%0d,%0d) to (%0d,%0d)",
                             $time, o_from_x, o_from_y, o_to_x, o_to_y);
                    errors++;
                end else begin
                    want = segs_due.pop_front();
                    check_field("from_x", want.from_x, o_from_x);
                    check_field("from_y", want.from_y, o_from_y);
                    check_field("to_x", want.to_x, o_to_x);
                    check_field("to_y", want.to_y, o_to_y);
                    check_field("red", 11'(want.red), 11'(o_red));
                    check_field("green", 11'(want.green), 11'(o_green));
                    check_field("blue", 11'(want.blue), 11'(o_blue));
                    check_field("last_segment", 11'(want.last), 11'(o_last_segment));
                end
                segs_seen++;
            end
            // hold off once for a long stretch so the block backs up
            if (!held && segs_seen >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (segs_seen >= 320 && segs_seen < 440) ||
                               ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : stim
        int r;
        int n;
        int eff;
        int useful;
        logic [2:0] d;
        useful = 0;

        // directed: idle word, wrap at both edges, depth clamps, zero step, restart mid-curve
        queue_word(1'b0);
        queue_cfg(pcsg_pkg::REG_CURVE_DEPTH, depth_data(3'd1));
        queue_cfg(pcsg_pkg::REG_STEP_LENGTH, 11'd2047);
        queue_cfg(pcsg_pkg::REG_START_X, 11'd2047);
        queue_cfg(pcsg_pkg::REG_START_Y, 11'd0);
        queue_word(1'b1);
        repeat (7) queue_word(1'b0);
        queue_word(1'b0);
        queue_cfg(pcsg_pkg::REG_CURVE_DEPTH, depth_data(3'd0));
        queue_cfg(pcsg_pkg::REG_STEP_LENGTH, 11'd0);
        queue_cfg(pcsg_pkg::REG_START_Y, 11'd2047);
        queue_word(1'b1);
        queue_word(1'b0);
        queue_cfg(pcsg_pkg::REG_CURVE_DEPTH, depth_data(3'd7));
        queue_cfg(pcsg_pkg::REG_STEP_LENGTH, 11'd5);
        queue_cfg(pcsg_pkg::REG_START_X, 11'd0);
        queue_cfg(pcsg_pkg::REG_START_Y, 11'd0);
        queue_word(1'b1);
        repeat (9) queue_word(1'b0);
        queue_word(1'b1);
        repeat (2) queue_word(1'b0);
        eff = pcsg_pkg::MAX_DEPTH;

        // random phases of mostly well-formed curve runs
        while (useful < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                // walk depth 2 until its top digit is 8, then shrink to depth 1
                queue_cfg(pcsg_pkg::REG_CURVE_DEPTH, depth_data(3'd2));
                queue_word(1'b1);
                repeat (71) queue_word(1'b0);
                queue_cfg(pcsg_pkg::REG_CURVE_DEPTH, depth_data(3'd1));
                queue_word(1'b0);
                queue_word(1'b0);
                eff = 1;
                useful += 72;
            end else begin
                if (r < 45) begin
                    if ($urandom_range(0, 1)) begin
                        d = pick_depth();
                        queue_cfg(pcsg_pkg::REG_CURVE_DEPTH, depth_data(d));
                        eff = (d == 0) ? 1 :
                              (d > pcsg_pkg::MAX_DEPTH) ? pcsg_pkg::MAX_DEPTH : int'(d);
                    end
                    if ($urandom_range(0, 1))
                        queue_cfg(pcsg_pkg::REG_STEP_LENGTH, pick_coord());
                    if ($urandom_range(0, 1))
                        queue_cfg(pcsg_pkg::REG_START_X, pick_coord());
                    if ($urandom_range(0, 1))
                        queue_cfg(pcsg_pkg::REG_START_Y, pick_coord());
                end
                n = (eff == 1) ? $urandom_range(3, 10) : $urandom_range(10, 85);
                queue_word($urandom_range(0, 99) < 85);
                for (int k = 1; k < n; k++) queue_word($urandom_range(0, 99) < 2);
                useful += (eff == 1 && n > 8) ? 8 : n;
            end
        end

        // hold reset, then release
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain stimulus, then outstanding segments, then a short tail
        while (pending.size() != 0 || i_in_valid || i_cfg_valid) @(posedge i_clk);
        while (segs_due.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        if (errors == 0) begin
            $display("peano_curve_segment_generator regression: pass");
        end else begin
            $display("peano_curve_segment_generator regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("peano_curve_segment_generator regression: fail");
        $finish;
    end

endmodule

>>> peano_curve_segment_generator.f
+incdir+design
design/pcsg_pkg.sv
design/peano_curve_segment_generator.sv
test/tb_peano_curve_segment_generator.sv
